// ===== hdl/pie_pkg.sv =====
// Shared types and constants for the positional insert/erase list.
// No dependencies; imported by every module in the block.
package pie_pkg;

  // Field widths fixed by the request and result formats
  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Default store depth and read reduction grouping
  localparam int DEFAULT_LIST_DEPTH = 64;
  localparam int READ_GROUP_SIZE    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Per-beat command broadcast to every cell
  typedef struct packed {
    logic ins;   // shift up from position, load value at position
    logic ers;   // shift down from position
    logic rd;    // drive the word at position onto the read bus
  } cell_ctrl_t;

endpackage

// ===== hdl/pie_cell.sv =====
// One storage cell of the list chain: holds a word, takes its neighbour's.
// Depends on pie_pkg.
module pie_cell
  import pie_pkg::*;
#(
  parameter int IDX_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [IDX_W-1:0]  pos_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  output logic [WORD_W-1:0] data_o,
  output logic [WORD_W-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [WORD_W-1:0] data_q, data_d;
  logic              is_at, is_above;

  assign is_at    = (pos_i == MyIdx);
  assign is_above = (MyIdx > pos_i);

  // Next word: from below on insert, from above on erase
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (is_above) data_d = left_i;
      else if (is_at) data_d = value_i;
    end else if (ctrl_i.ers) begin
      if (is_above || is_at) data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives the read bus
  assign rd_o   = (ctrl_i.rd && is_at) ? data_q : '0;

endmodule

// ===== hdl/pie_read_tree.sv =====
// Registered OR reduction of the cell read outputs, in fixed-size groups.
// Depends on pie_pkg.
module pie_read_tree
  import pie_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [WORD_W-1:0] rd_i [LIST_DEPTH],
  output logic [WORD_W-1:0] rd_o
);

  localparam int NumGroups = (LIST_DEPTH + READ_GROUP_SIZE - 1) / READ_GROUP_SIZE;

  logic [WORD_W-1:0] grp_q [NumGroups];
  logic [WORD_W-1:0] grp_d [NumGroups];

  // First level: OR within each group, registered on the beat
  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    localparam int Base = g * READ_GROUP_SIZE;
    localparam int Span = (LIST_DEPTH - Base < READ_GROUP_SIZE) ?
                          (LIST_DEPTH - Base) : READ_GROUP_SIZE;
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < Span; k++) begin
        grp_d[g] = grp_d[g] | rd_i[Base + k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (load_i) grp_q[g] <= grp_d[g];
    end
  end

  // Second level: OR across the group registers
  always_comb begin
    rd_o = '0;
    for (int g = 0; g < NumGroups; g++) begin
      rd_o = rd_o | grp_q[g];
    end
  end

endmodule

// ===== hdl/positional_insert_erase_list.sv =====
// Top level of the positional insert/erase list: cell chain, count, result path.
// Depends on pie_pkg, pie_cell and pie_read_tree.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------
//  request | valid_i / stall_o  | operation_i, value_i, position_i
//  result  | valid_o / stall_i  | status_o, read_value_o, count_o
//
// One request is taken every cycle unless stall_o is high. Insert and erase shift
// the cells at and above the position at once on the accepting edge; the result
// passes the grouped read reduction and stage 1, then the result register.
// Reset clears the count and the pipeline; cell contents stay undefined until
// written and need no clearing pass. A stalled result holds; requests stall
// only when both the read stage and the result register are occupied.
module positional_insert_erase_list
  import pie_pkg::*;
#(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [OP_W-1:0]            operation_i,
  input  logic signed [WORD_W-1:0]   value_i,
  input  logic [POS_W-1:0]           position_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [WORD_W-1:0]   read_value_o,
  output logic [COUNT_W-1:0]         count_o
);

  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [CntW-1:0] Depth = CntW'(LIST_DEPTH);

  // Handshake and pipeline occupancy
  logic in_acc, out_free, s1_free;
  logic s1_q, out_valid_q;

  assign out_free = !out_valid_q || !stall_i;
  assign s1_free  = !s1_q || out_free;
  assign stall_o  = !s1_free;
  assign in_acc   = valid_i && s1_free;

  // Request decode and status against the current count
  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] cnt_ext, pos_ext;
  status_e         st_d;
  cell_ctrl_t      ctrl;

  assign cnt_ext = CmpW'(count_q);
  assign pos_ext = CmpW'(position_i);

  always_comb begin
    st_d    = ST_OK;
    ctrl    = '0;
    count_d = count_q;
    unique case (operation_i)
      OP_INSERT: begin
        if (count_q == Depth) st_d = ST_FULL;
        else if (pos_ext > cnt_ext) st_d = ST_BADPOS;
        else begin
          ctrl.ins = in_acc;
          count_d  = count_q + CntW'(1);
        end
      end
      OP_ERASE: begin
        if (count_q == '0) st_d = ST_EMPTY;
        else if (pos_ext >= cnt_ext) st_d = ST_BADPOS;
        else begin
          ctrl.ers = in_acc;
          count_d  = count_q - CntW'(1);
        end
      end
      OP_READ: begin
        if (count_q == '0) st_d = ST_EMPTY;
        else if (pos_ext >= cnt_ext) st_d = ST_BADPOS;
        else ctrl.rd = in_acc;
      end
      default: ;
    endcase
  end

  // Cell chain
  logic [WORD_W-1:0] cell_data [LIST_DEPTH];
  logic [WORD_W-1:0] cell_rd   [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    pie_cell #(
      .IDX_W    (CmpW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Read reduction, first level loaded with the beat
  logic [WORD_W-1:0] rd_word;

  pie_read_tree #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_read_tree (
    .clk_i  (clk_i),
    .load_i (in_acc),
    .rd_i   (cell_rd),
    .rd_o   (rd_word)
  );

  // Stage 1 status/count and result register
  status_e           s1_st_q, out_st_q;
  logic [CntW-1:0]   s1_cnt_q, out_cnt_q;
  logic [WORD_W-1:0] out_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) count_q <= count_d;
      if (in_acc) s1_q <= 1'b1;
      else if (out_free) s1_q <= 1'b0;
      if (out_free) out_valid_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_st_q  <= st_d;
      s1_cnt_q <= count_d;
    end
    if (out_free && s1_q) begin
      out_st_q  <= s1_st_q;
      out_cnt_q <= s1_cnt_q;
      out_rd_q  <= rd_word;
    end
  end

  logic [CmpW-1:0] out_cnt_ext;
  assign out_cnt_ext  = CmpW'(out_cnt_q);

  assign valid_o      = out_valid_q;
  assign status_o     = out_st_q;
  assign read_value_o = out_rd_q;
  assign count_o      = out_cnt_ext[COUNT_W-1:0];

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("list count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted insert did not grow the list");

  a_erase_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ctrl.ers |=> count_q == $past(count_q) - CntW'(1))
    else $error("accepted erase did not shrink the list");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q && out_free |=> valid_o)
    else $error("stage 1 beat lost on its way to the result register");

endmodule
